/* rtl/dcd_pkg.sv */
`timescale 1ns / 1ps

package dcd_pkg;

  // Default width of the decoded source and target sizes.
  localparam int DEFAULT_SIZE_WIDTH = 32;

  // Depth of the result queue in front of the output port.
  localparam int OUT_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_COPY    = 2'd1;
  localparam logic [1:0] KIND_LITERAL = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Final status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO_CMD   = 3'd1;
  localparam logic [2:0] ST_BEYOND     = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_MISMATCH   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;
  localparam logic [2:0] ST_SIZE_OVF   = 3'd6;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] copy_offset;
    logic [24:0] copy_length;
    logic [7:0]  literal;
    logic [31:0] out_position;
    logic [31:0] source_size;
    logic [31:0] target_size;
    logic [2:0]  status;
    logic        last_result;
  } dcd_result_t;

  // Results produced by one input item, in order: first, then second.
  typedef struct packed {
    logic [1:0]  count;
    dcd_result_t first;
    dcd_result_t second;
  } dcd_push_t;

endpackage

/* rtl/dcd_core.sv */
`timescale 1ns / 1ps

module dcd_core import dcd_pkg::*; #(
  parameter int SIZE_WIDTH = DEFAULT_SIZE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [31:0] in_base,
  input  logic        room,
  output dcd_push_t   push
);

  localparam logic [2:0] PH_SRC   = 3'd0;
  localparam logic [2:0] PH_DST   = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_COPY  = 3'd3;
  localparam logic [2:0] PH_INS   = 3'd4;
  localparam logic [2:0] PH_DRAIN = 3'd5;

  localparam int         CW        = ((SIZE_WIDTH > 25) ? SIZE_WIDTH : 25) + 1;
  localparam logic [6:0] SW7       = 7'(SIZE_WIDTH);
  localparam logic [6:0] SHIFT_MAX = 7'd70;

  // Input register.
  logic        s_valid_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;
  logic [31:0] s_base_r;
  logic        advance;

  // Decoder state.
  logic [2:0]            phase_r, phase_nxt;
  logic [SIZE_WIDTH-1:0] acc_r, acc_nxt;
  logic [6:0]            shift_r, shift_nxt;
  logic [SIZE_WIDTH-1:0] src_r, src_nxt;
  logic [SIZE_WIDTH-1:0] dst_r, dst_nxt;
  logic [31:0]           base_r, base_nxt;
  logic [6:0]            mask_r, mask_nxt;
  logic [31:0]           off_r, off_nxt;
  logic [23:0]           len_r, len_nxt;
  logic [6:0]            ins_left_r, ins_left_nxt;
  logic [SIZE_WIDTH-1:0] written_r, written_nxt;
  logic [2:0]            err_r, err_nxt;

  // Varint step.
  logic [6:0]            chunk;
  logic                  shift_ge;
  logic [6:0]            room7;
  logic [6:0]            room_hi;
  logic                  vi_ovf;
  logic                  vi_done;
  logic [SIZE_WIDTH-1:0] vi_acc;
  logic [6:0]            shift_sum;
  logic [6:0]            vi_shift;

  // Copy operand placement and checks.
  logic [6:0]  low_bit;
  logic [31:0] cp_off;
  logic [23:0] cp_len;
  logic [6:0]  cp_mask;
  logic [31:0] fin_off;
  logic [23:0] fin_raw;
  logic [24:0] fin_len;
  logic        fin_beyond;
  logic        fin_over;
  logic        ins_over;

  // Results of this item.
  logic        fail_v;
  logic [2:0]  fail_code;
  logic        d_v;
  dcd_result_t d_res;
  dcd_result_t s_res;
  logic [2:0]  st_code;

  assign advance  = s_valid_r && room;
  assign in_ready = !s_valid_r || advance;

  // Input register: takes an item whenever the previous one moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte_r <= in_byte;
      s_last_r <= in_last;
      s_base_r <= in_base;
    end
  end

  // One varint byte: seven data bits at the current shift.
  always_comb begin
    chunk     = s_byte_r[6:0];
    shift_ge  = shift_r >= SW7;
    room7     = SW7 - shift_r;
    room_hi   = chunk >> room7[2:0];
    vi_ovf    = (chunk != 7'd0) &&
                (shift_ge || ((room7 < 7'd7) && (room_hi != 7'd0)));
    vi_acc    = acc_r | (SIZE_WIDTH'(chunk) << shift_r);
    vi_done   = !s_byte_r[7];
    shift_sum = shift_r + 7'd7;
    vi_shift  = (shift_sum > SHIFT_MAX) ? SHIFT_MAX : shift_sum;
  end

  // Copy operands: the lowest mask bit still set picks the byte's place.
  always_comb begin
    low_bit = mask_r & (~mask_r + 7'd1);
    cp_off  = off_r;
    cp_len  = len_r;
    for (int i = 0; i < 4; i++) begin
      if (low_bit[i]) begin
        cp_off[8*i +: 8] = cp_off[8*i +: 8] | s_byte_r;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (low_bit[4+i]) begin
        cp_len[8*i +: 8] = cp_len[8*i +: 8] | s_byte_r;
      end
    end
    cp_mask = mask_r & (mask_r - 7'd1);
  end

  // Checks of a finished copy and of a new insert, exact and without wrap.
  always_comb begin
    fin_off    = (phase_r == PH_COPY) ? cp_off : 32'd0;
    fin_raw    = (phase_r == PH_COPY) ? cp_len : 24'd0;
    fin_len    = (fin_raw == 24'd0) ? 25'h10000 : {1'b0, fin_raw};
    fin_beyond = ({1'b0, fin_off} + 33'(fin_len)) > {1'b0, base_r};
    fin_over   = (CW'(written_r) + CW'(fin_len)) > CW'(dst_r);
    ins_over   = (CW'(written_r) + CW'(s_byte_r)) > CW'(dst_r);
  end

  // Next state and results for the item in the input register.
  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    shift_nxt    = shift_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    base_nxt     = base_r;
    mask_nxt     = mask_r;
    off_nxt      = off_r;
    len_nxt      = len_r;
    ins_left_nxt = ins_left_r;
    written_nxt  = written_r;
    err_nxt      = err_r;
    fail_v       = 1'b0;
    fail_code    = ST_OK;
    d_v          = 1'b0;
    d_res        = '0;
    s_res        = '0;
    st_code      = ST_OK;

    case (phase_r)
      PH_SRC, PH_DST: begin
        if ((phase_r == PH_SRC) && (shift_r == 7'd0)) begin
          base_nxt = s_base_r;
        end
        if (vi_ovf) begin
          fail_v    = 1'b1;
          fail_code = ST_SIZE_OVF;
        end else if (vi_done) begin
          acc_nxt   = '0;
          shift_nxt = 7'd0;
          if (phase_r == PH_SRC) begin
            src_nxt   = vi_acc;
            phase_nxt = PH_DST;
          end else begin
            dst_nxt            = vi_acc;
            phase_nxt          = PH_CMD;
            d_v                = 1'b1;
            d_res.kind         = KIND_HEADER;
            d_res.source_size  = 32'(src_r);
            d_res.target_size  = 32'(vi_acc);
            d_res.out_position = 32'(written_r);
          end
        end else begin
          acc_nxt   = vi_acc;
          shift_nxt = vi_shift;
        end
      end
      PH_CMD, PH_COPY: begin
        if (phase_r == PH_COPY) begin
          off_nxt  = cp_off;
          len_nxt  = cp_len;
          mask_nxt = cp_mask;
        end
        // A copy is complete with its command byte or its last operand byte.
        if (((phase_r == PH_CMD) && s_byte_r[7] && (s_byte_r[6:0] == 7'd0)) ||
            ((phase_r == PH_COPY) && (cp_mask == 7'd0))) begin
          if (phase_r == PH_CMD) begin
            mask_nxt = 7'd0;
            off_nxt  = 32'd0;
            len_nxt  = 24'd0;
          end
          if (fin_beyond) begin
            fail_v    = 1'b1;
            fail_code = ST_BEYOND;
          end else if (fin_over) begin
            fail_v    = 1'b1;
            fail_code = ST_OVERRUN;
          end else begin
            d_v                = 1'b1;
            d_res.kind         = KIND_COPY;
            d_res.copy_offset  = fin_off;
            d_res.copy_length  = fin_len;
            d_res.out_position = 32'(written_r);
            written_nxt        = written_r + SIZE_WIDTH'(fin_len);
            phase_nxt          = PH_CMD;
          end
        end else if (phase_r == PH_CMD) begin
          if (s_byte_r[7]) begin
            mask_nxt  = s_byte_r[6:0];
            off_nxt   = 32'd0;
            len_nxt   = 24'd0;
            phase_nxt = PH_COPY;
          end else if (s_byte_r == 8'd0) begin
            fail_v    = 1'b1;
            fail_code = ST_ZERO_CMD;
          end else if (ins_over) begin
            fail_v    = 1'b1;
            fail_code = ST_OVERRUN;
          end else begin
            ins_left_nxt = s_byte_r[6:0];
            phase_nxt    = PH_INS;
          end
        end
      end
      PH_INS: begin
        d_v                = 1'b1;
        d_res.kind         = KIND_LITERAL;
        d_res.literal      = s_byte_r;
        d_res.out_position = 32'(written_r);
        written_nxt        = written_r + SIZE_WIDTH'(1);
        ins_left_nxt       = ins_left_r - 7'd1;
        if (ins_left_r == 7'd1) begin
          phase_nxt = PH_CMD;
        end
      end
      default: begin
      end
    endcase

    // The first error is kept and the rest of the delta is skipped.
    if (fail_v) begin
      if (err_r == ST_OK) begin
        err_nxt = fail_code;
      end
      phase_nxt = PH_DRAIN;
    end

    // Final status on the last byte, then back to the reset state.
    if (s_last_r) begin
      if (err_nxt != ST_OK) begin
        st_code = err_nxt;
      end else if (phase_nxt != PH_CMD) begin
        st_code = ST_TRUNCATED;
      end else if (written_nxt != dst_nxt) begin
        st_code = ST_MISMATCH;
      end else begin
        st_code = ST_OK;
      end
      s_res.kind         = KIND_STATUS;
      s_res.status       = st_code;
      s_res.last_result  = 1'b1;
      s_res.out_position = 32'(written_nxt);

      phase_nxt    = PH_SRC;
      acc_nxt      = '0;
      shift_nxt    = 7'd0;
      src_nxt      = '0;
      dst_nxt      = '0;
      base_nxt     = 32'd0;
      mask_nxt     = 7'd0;
      off_nxt      = 32'd0;
      len_nxt      = 24'd0;
      ins_left_nxt = 7'd0;
      written_nxt  = '0;
      err_nxt      = ST_OK;
    end
  end

  // Results go to the queue in order, the data result first.
  always_comb begin
    push.count  = advance ? ({1'b0, d_v} + {1'b0, s_last_r}) : 2'd0;
    push.first  = d_v ? d_res : s_res;
    push.second = s_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SRC;
      acc_r      <= '0;
      shift_r    <= 7'd0;
      src_r      <= '0;
      dst_r      <= '0;
      base_r     <= 32'd0;
      mask_r     <= 7'd0;
      off_r      <= 32'd0;
      len_r      <= 24'd0;
      ins_left_r <= 7'd0;
      written_r  <= '0;
      err_r      <= ST_OK;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      base_r     <= base_nxt;
      mask_r     <= mask_nxt;
      off_r      <= off_nxt;
      len_r      <= len_nxt;
      ins_left_r <= ins_left_nxt;
      written_r  <= written_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

/* rtl/dcd_out_fifo.sv */
`timescale 1ns / 1ps

module dcd_out_fifo import dcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dcd_push_t   push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output dcd_result_t out_data
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  dcd_result_t      entry_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  logic [CNT_W-1:0] after_pop;

  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Room for two results once this cycle's pop is counted.
  assign after_pop = count_r - CNT_W'(pop);
  assign room      = (after_pop <= CNT_W'(OUT_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Up to two results are written per cycle at consecutive slots.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[PTR_W'(wr_ptr_r + 1'b1)] <= push.second;
    end
  end

endmodule

/* rtl/delta_command_decoder.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                         Carries
// -------   ---------  ----------------------------  ------------------------------
// in_       slave      in_tvalid/tready/tdata/tlast  one delta byte per item
// out_      master     out_tvalid/tready/tdata/      header, copy, literal or final
//                      tuser/tlast                   status per item
//
// One input item is taken per cycle while the queue has room and is decoded in a
// single pass between the input register and a four-entry result queue, from
// which its results are offered. A last byte that also carries data gives two
// results, and the output port then sets the pace. Reset is synchronous and active
// low and leaves the decoder waiting for the source size. A stalled output fills the
// queue; the input register hands on its item only while two queue slots stay free.

module delta_command_decoder import dcd_pkg::*; #(
  parameter int SIZE_WIDTH = DEFAULT_SIZE_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // delta_byte [7:0], base_length [39:8]
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // copy_offset [31:0], copy_length [56:32],
                                   // literal [64:57], out_position [96:65],
                                   // source_size [128:97], target_size [160:129],
                                   // status [163:161], zero [167:164]
  output logic [1:0]   out_tuser,  // kind [1:0]
  output logic         out_tlast   // last_result
);

  dcd_push_t   push;
  logic        room;
  dcd_result_t res;

  dcd_core #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata[7:0]),
    .in_last  (in_tlast),
    .in_base  (in_tdata[39:8]),
    .room     (room),
    .push     (push)
  );

  dcd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // Pack the result item onto the output bus.
  assign out_tdata = {4'b0000, res.status, res.target_size, res.source_size,
                      res.out_position, res.literal, res.copy_length,
                      res.copy_offset};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;

  // The decoder never pushes more results than the queue has room for.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> room)
    else $error("result pushed without queue room");

  // An item gives at most two results.
  assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd3)
    else $error("three results from one item");

  // Only a final status result closes a delta.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == KIND_STATUS))
    else $error("last result is not a status result");

  // Data results carry no status code.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_STATUS)) |-> (out_tdata[163:161] == ST_OK))
    else $error("status set on a data result");

endmodule
